// ===== src/trdfifo_pkg.sv =====
// ----------------------------------------------------------------------------
// trdfifo_pkg
// Shared types and fixed constants for the timed-release frame descriptor FIFO.
// ----------------------------------------------------------------------------
package trdfifo_pkg;

  // Field widths fixed by the interface
  localparam int TIME_W   = 48;
  localparam int DELAY_W  = 16;
  localparam int CAP_W    = 10;
  localparam int HANDLE_W = 16;
  localparam int SIZE_W   = 12;
  localparam int OCC_W    = 10;
  localparam int OP_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_POP   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_MS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'b1;

  // Reset value of the capacity register
  localparam logic [CAP_W-1:0] CAPACITY_RST = 10'd512;

  // One stored frame descriptor
  typedef struct packed {
    logic [TIME_W-1:0]   render_time;
    logic [TIME_W-1:0]   enqueue_time;
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
  } desc_t;

endpackage

// ===== src/trdfifo_ram.sv =====
// ----------------------------------------------------------------------------
// trdfifo_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module trdfifo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/timed_release_drop_oldest_fifo_top.sv =====
// ----------------------------------------------------------------------------
// timed_release_drop_oldest_fifo_top
// Bounded FIFO of frame descriptors released after a programmable hold time.
// ----------------------------------------------------------------------------
// Each transfer on the input channel carries one operation: push a
// descriptor, try to release the head, or clear the queue. Every operation
// gives exactly one result transfer. The accept cycle issues the head read
// to the descriptor RAM; in the EXEC state, once the output register is
// free, the operation is evaluated on the registered read data, a pushed
// descriptor is written at the tail and the output register is loaded. A
// new operation is accepted only after the current one has been evaluated.
// A push with a zero hold time, a zero size or a size above MAX_FRAME_BYTES
// is refused. When the queue is full (capacity entries, capacity clamped to
// 1..DEPTH), a push drops the oldest descriptor and flags it. Configuration
// writes are meant for idle periods only.
// ----------------------------------------------------------------------------
module timed_release_drop_oldest_fifo_top
  import trdfifo_pkg::*;
#(
  parameter int DEPTH           = 512,
  parameter int MAX_FRAME_BYTES = 1920
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // operation input
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OP_W-1:0]       in_opcode,
  input  logic [TIME_W-1:0]     in_render_time,
  input  logic [TIME_W-1:0]     in_now_time,
  input  logic [HANDLE_W-1:0]   in_frame_handle,
  input  logic [SIZE_W-1:0]     in_frame_size,
  // result output
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_ok,
  output logic                  out_dropped_oldest,
  output logic [TIME_W-1:0]     out_render_time,
  output logic [TIME_W-1:0]     out_enqueue_time,
  output logic [HANDLE_W-1:0]   out_handle,
  output logic [SIZE_W-1:0]     out_size,
  output logic [OCC_W-1:0]      out_occupancy
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = (CW > CAP_W) ? CW : CAP_W;
  localparam int DW = $bits(desc_t);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  // Control state
  logic               state_r, state_nxt;
  logic [IW-1:0]      head_r, head_nxt;
  logic [IW-1:0]      tail_r, tail_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [DELAY_W-1:0] delay_r;
  logic [CAP_W-1:0]   cap_r;
  logic               out_valid_r;

  // Captured operation
  logic [OP_W-1:0]     op_r;
  logic [TIME_W-1:0]   rt_r;
  logic [TIME_W-1:0]   now_r;
  logic [HANDLE_W-1:0] hdl_r;
  logic [SIZE_W-1:0]   sz_r;

  // Output register
  logic                out_ok_r, out_ok_nxt;
  logic                out_drop_r, out_drop_nxt;
  desc_t               out_desc_r, out_desc_nxt;
  logic [OCC_W-1:0]    out_occ_r;

  // RAM signals
  logic        ram_we;
  desc_t       ram_wdesc;
  logic [DW-1:0] ram_rdata;
  desc_t       head_desc;

  logic          accept;
  logic          out_free;
  logic          exec_go;
  logic          push_ok;
  logic          full;
  logic          release_ok;
  logic [EW-1:0] cap_ext;
  logic [EW-1:0] cap_eff;
  logic [EW-1:0] count_ext;
  logic [TIME_W:0] release_time;
  logic [IW-1:0] head_inc;
  logic [IW-1:0] tail_inc;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign exec_go  = (state_r == S_EXEC) && out_free;

  // Descriptor store
  trdfifo_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_desc_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (ram_wdesc),
    .re    (accept),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  assign head_desc = desc_t'(ram_rdata);

  // Pointer increments with wrap at DEPTH
  assign head_inc = (head_r == IW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == IW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;

  // Capacity clamped to 1..DEPTH
  assign cap_ext   = EW'(cap_r);
  assign count_ext = EW'(count_r);
  always_comb begin
    if (cap_ext == '0) begin
      cap_eff = EW'(1);
    end else if (cap_ext > EW'(DEPTH)) begin
      cap_eff = EW'(DEPTH);
    end else begin
      cap_eff = cap_ext;
    end
  end

  // Push admission and overflow
  assign push_ok = (delay_r != '0) && (sz_r != '0) &&
                   (sz_r <= SIZE_W'(MAX_FRAME_BYTES));
  assign full    = (count_ext >= cap_eff) && (count_r != '0);

  // Release time formed without wrap
  assign release_time = {1'b0, head_desc.render_time} + (TIME_W + 1)'(delay_r);
  assign release_ok   = (count_r != '0) && ({1'b0, now_r} >= release_time);

  // Descriptor written on push
  always_comb begin
    ram_wdesc.render_time  = rt_r;
    ram_wdesc.enqueue_time = now_r;
    ram_wdesc.handle       = hdl_r;
    ram_wdesc.size         = sz_r;
  end
  assign ram_we = exec_go && (op_r == OP_PUSH) && push_ok;

  // Operation evaluation
  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    out_ok_nxt   = 1'b0;
    out_drop_nxt = 1'b0;
    out_desc_nxt = '0;
    case (op_r)
      OP_PUSH: begin
        if (push_ok) begin
          out_ok_nxt = 1'b1;
          tail_nxt   = tail_inc;
          if (full) begin
            out_drop_nxt = 1'b1;
            head_nxt     = head_inc;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
      end
      OP_POP: begin
        if (release_ok) begin
          out_ok_nxt   = 1'b1;
          out_desc_nxt = head_desc;
          head_nxt     = head_inc;
          count_nxt    = count_r - 1'b1;
        end
      end
      OP_CLEAR: begin
        out_ok_nxt = 1'b1;
        head_nxt   = '0;
        tail_nxt   = '0;
        count_nxt  = '0;
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (exec_go) begin
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        count_r <= count_nxt;
      end
      if (exec_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= '0;
      cap_r   <= CAPACITY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DELAY_MS: delay_r <= cfg_data;
        REG_CAPACITY: cap_r   <= cfg_data[CAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Operation capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_opcode;
      rt_r  <= in_render_time;
      now_r <= in_now_time;
      hdl_r <= in_frame_handle;
      sz_r  <= in_frame_size;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_ok_r   <= out_ok_nxt;
      out_drop_r <= out_drop_nxt;
      out_desc_r <= out_desc_nxt;
      out_occ_r  <= OCC_W'(count_nxt);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_ok             = out_ok_r;
  assign out_dropped_oldest = out_drop_r;
  assign out_render_time    = out_desc_r.render_time;
  assign out_enqueue_time   = out_desc_r.enqueue_time;
  assign out_handle         = out_desc_r.handle;
  assign out_size           = out_desc_r.size;
  assign out_occupancy      = out_occ_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_r == tail_r))
    else $error("empty queue with head and tail apart");

  a_drop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_drop_r) |-> out_ok_r)
    else $error("drop flagged on refused operation");

  a_no_release_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> (out_desc_r == '0))
    else $error("release fields set on refused operation");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC))
    else $error("accepted operation not evaluated");

endmodule
